>>> src/word_dictionary_table_unit_macros.svh
// Assertion macros for the word dictionary table unit.
`ifndef WORD_DICTIONARY_TABLE_UNIT_MACROS_SVH
`define WORD_DICTIONARY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WDT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WDT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/wdt_pkg.sv
// Package: sizes, command and status codes, control structs of the dictionary table.
`timescale 1ns / 1ps

package wdt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 64;

    localparam int KEY_IN_W = 64;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_CNT_W = 6;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Command codes
    localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] OP_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] OP_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [CMD_W-1:0] OP_UPDATE = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic scan_step;
        logic set_result;
        logic wr_insert;
        logic wr_update;
        logic clr_count;
        logic rd_last;
        logic wr_move;
        logic load_out;
    } wdt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             found;
        logic             scan_done;
        logic             full;
        logic             out_free;
    } wdt_stat_t;

endpackage

>>> src/wdt_ctrl.sv
// Controller state machine: sequences scan, table update and result hand-off.
`timescale 1ns / 1ps

module wdt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wdt_pkg::wdt_stat_t stat,
    output wdt_pkg::wdt_cmd_t  cmd
);
    import wdt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                cmd.set_result = 1'b1;
                cmd.wr_insert  = (stat.op == OP_INSERT) && !stat.found && !stat.full;
                cmd.wr_update  = (stat.op == OP_UPDATE) && stat.found;
                cmd.clr_count  = (stat.op == OP_CLEAR);
                if ((stat.op == OP_DELETE) && stat.found) begin
                    state_next = S_LAST;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LAST: begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE: begin
                cmd.wr_move = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/wdt_dpath.sv
// Datapath: key memory, word count, scan compare, result and output registers.
`timescale 1ns / 1ps

module wdt_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [wdt_pkg::CMD_W-1:0]           s_command,
    input  logic [wdt_pkg::KEY_IN_W-1:0]        s_key,
    input  logic [wdt_pkg::KEY_IN_W-1:0]        s_new_key,
    input  wdt_pkg::wdt_cmd_t                   cmd,
    output wdt_pkg::wdt_stat_t                  stat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_success,
    output logic [wdt_pkg::STATUS_W-1:0]        m_status,
    output logic [wdt_pkg::OUT_CNT_W-1:0]       m_entry_count
);
    import wdt_pkg::*;

    // Key storage, one write and one registered read port
    logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] rd_data_reg;

    // Transaction registers
    logic [CMD_W-1:0]    op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] new_key_reg;

    // Scan state
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             found_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result and output registers
    logic                res_success_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_valid_reg;
    logic                m_success_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [OUT_CNT_W-1:0] m_count_reg;

    logic [CNT_W-1:0]    last_cnt;
    logic [IDX_W-1:0]    rd_addr;
    logic                issue;
    logic                hit;
    logic                full;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic                res_success;
    logic [STATUS_W-1:0] res_status;

    assign last_cnt = count_reg - CNT_W'(1);
    assign rd_addr  = cmd.rd_last ? last_cnt[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign issue    = cmd.scan_step && (idx_reg < count_reg) && !found_reg;
    assign hit      = cmp_vld_reg && (rd_data_reg == key_reg) && !found_reg;
    assign full     = (count_reg >= CNT_W'(TABLE_DEPTH));

    // Write port select
    always_comb begin
        mem_we  = cmd.wr_insert || cmd.wr_update || cmd.wr_move;
        wr_addr = pos_reg;
        wr_data = rd_data_reg;
        if (cmd.wr_insert) begin
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = key_reg;
        end else if (cmd.wr_update) begin
            wr_data = new_key_reg;
        end
    end

    // Memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Transaction capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg      <= s_command;
            key_reg     <= s_key[KEY_BITS-1:0];
            new_key_reg <= s_new_key[KEY_BITS-1:0];
        end
        if (issue) begin
            cmp_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (hit) begin
            pos_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else if (cmd.load_in) begin
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            cmp_vld_reg <= issue;
            if (issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Word count
    always_comb begin
        count_next = count_reg;
        if (cmd.clr_count) begin
            count_next = '0;
        end else if (cmd.wr_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.wr_move) begin
            count_next = last_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result decode from the finished scan
    always_comb begin
        res_success = 1'b0;
        res_status  = ST_NOT_FOUND;
        case (op_reg)
            OP_CLEAR: begin
                res_success = 1'b1;
                res_status  = ST_OK;
            end
            OP_INSERT: begin
                if (found_reg) begin
                    res_status = ST_DUPLICATE;
                end else if (full) begin
                    res_status = ST_FULL;
                end else begin
                    res_success = 1'b1;
                    res_status  = ST_OK;
                end
            end
            OP_DELETE, OP_LOOKUP, OP_UPDATE: begin
                if (found_reg) begin
                    res_success = 1'b1;
                    res_status  = ST_OK;
                end
            end
            default: begin
                res_success = 1'b0;
                res_status  = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_result) begin
            res_success_reg <= res_success;
            res_status_reg  <= res_status;
        end
        if (cmd.load_out) begin
            m_success_reg <= res_success_reg;
            m_status_reg  <= res_status_reg;
            m_count_reg   <= OUT_CNT_W'(count_reg);
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.op        = op_reg;
    assign stat.found     = found_reg;
    assign stat.scan_done = found_reg || (!cmp_vld_reg && (idx_reg >= count_reg));
    assign stat.full      = full;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_success     = m_success_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

endmodule

>>> src/word_dictionary_table_unit.sv
// A transaction scans the stored keys, then acts on the table and loads the result.
// A delete that hits also passes through the S_LAST and S_MOVE states. The scan reads one stored key per cycle.
// One transaction at a time; the next is accepted the cycle after the result is loaded,
// so the block cannot take a new transaction before it is through with the last one.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
// Stored keys are not cleared; no entry at or above the word count is ever compared or moved.
`timescale 1ns / 1ps
`include "word_dictionary_table_unit_macros.svh"

module word_dictionary_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wdt_pkg::CMD_W-1:0]     s_command,
    input  logic [wdt_pkg::KEY_IN_W-1:0]  s_key,
    input  logic [wdt_pkg::KEY_IN_W-1:0]  s_new_key,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_success,
    output logic [wdt_pkg::STATUS_W-1:0]  m_status,
    output logic [wdt_pkg::OUT_CNT_W-1:0] m_entry_count
);
    import wdt_pkg::*;

    wdt_cmd_t  cmd;
    wdt_stat_t stat;

    wdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wdt_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_new_key     (s_new_key),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    // Checks
    `WDT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted a transaction while busy")
    `WDT_ASSERT_NOW(a_no_result_overwrite, aclk, aresetn, cmd.load_out, !m_valid || m_ready, "result overwritten before taken")
    `WDT_ASSERT_NOW(a_success_matches_ok, aclk, aresetn, m_valid, m_success == (m_status == ST_OK), "success and status disagree")
    `WDT_ASSERT_NOW(a_count_bound, aclk, aresetn, m_valid, m_entry_count <= OUT_CNT_W'(TABLE_DEPTH), "word count beyond table depth")

endmodule

>>> tb/word_dictionary_table_unit_tb.sv
// Self-checking testbench for the word dictionary table unit: directed and random commands.
`timescale 1ns / 1ps

module word_dictionary_table_unit_tb;
    import wdt_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 417;
    localparam int SEGMENT_LEN     = 40;
    localparam int POOL_SIZE       = 40;
    localparam int DRAIN_CYCLES    = TABLE_DEPTH + 16;
    localparam int STALL_LIMIT     = 5000;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] OP_RSVD_C = 3'd7;

    typedef struct packed {
        logic                 success;
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] count;
    } reply_t;

    // Mirror of the table contents and the queue of replies still owed
    class dictionary_mirror;
        logic [KEY_BITS-1:0] stored_words [TABLE_DEPTH];
        int unsigned         word_total;
        reply_t              pending_replies [$];
        int unsigned         errors;

        function new();
            word_total = 0;
            errors     = 0;
        endfunction

        // Lowest matching slot, or -1 when absent
        function int find_word(logic [KEY_BITS-1:0] k);
            for (int i = 0; i < word_total; i++) begin
                if (stored_words[i] == k)
                    return i;
            end
            return -1;
        endfunction

        // Apply one accepted command and queue the reply it must produce
        function void apply_command(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] key,
                                    logic [KEY_IN_W-1:0] nkey);
            logic [KEY_BITS-1:0] k;
            logic [KEY_BITS-1:0] nk;
            int                  pos;
            reply_t              r;
            k         = key[KEY_BITS-1:0];
            nk        = nkey[KEY_BITS-1:0];
            pos       = find_word(k);
            r.success = 1'b0;
            r.status  = ST_NOT_FOUND;
            case (cmd)
                OP_CLEAR: begin
                    word_total = 0;
                    r.success  = 1'b1;
                    r.status   = ST_OK;
                end
                OP_INSERT: begin
                    // duplicate is checked before fullness
                    if (pos >= 0) begin
                        r.status = ST_DUPLICATE;
                    end else if (word_total >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        stored_words[word_total] = k;
                        word_total++;
                        r.success = 1'b1;
                        r.status  = ST_OK;
                    end
                end
                OP_DELETE: if (pos >= 0) begin
                    // last entry fills the hole
                    word_total--;
                    stored_words[pos] = stored_words[word_total];
                    r.success = 1'b1;
                    r.status  = ST_OK;
                end
                OP_LOOKUP: if (pos >= 0) begin
                    r.success = 1'b1;
                    r.status  = ST_OK;
                end
                OP_UPDATE: if (pos >= 0) begin
                    stored_words[pos] = nk;
                    r.success = 1'b1;
                    r.status  = ST_OK;
                end
                default: ;
            endcase
            r.count = word_total[OUT_CNT_W-1:0];
            pending_replies.push_back(r);
        endfunction

        // Compare one received reply with the oldest one owed
        function void check_reply(logic success, logic [STATUS_W-1:0] status,
                                  logic [OUT_CNT_W-1:0] count);
            reply_t want;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply success=%0d status=%0d count=%0d",
                         $time, success, status, count);
                return;
            end
            want = pending_replies.pop_front();
            if (success !== want.success) begin
                errors++;
                $display("%0t: success mismatch expected=%0d actual=%0d",
                         $time, want.success, success);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, want.status, status);
            end
            if (count !== want.count) begin
                errors++;
                $display("%0t: entry_count mismatch expected=%0d actual=%0d",
                         $time, want.count, count);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command     = OP_CLEAR;
    logic [KEY_IN_W-1:0]   s_key         = '0;
    logic [KEY_IN_W-1:0]   s_new_key     = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_success;
    logic [STATUS_W-1:0]   m_status;
    logic [OUT_CNT_W-1:0]  m_entry_count;

    dictionary_mirror      dictionary;
    logic [KEY_IN_W-1:0]   key_pool [POOL_SIZE];
    int                    src_idle_pct = 0;
    int                    snk_idle_pct = 0;
    int                    items_sent   = 0;
    int                    stall_cycles = 0;

    word_dictionary_table_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_new_key     (s_new_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Reply checking, result-side backpressure and the stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            dictionary.check_reply(m_success, m_status, m_entry_count);
        m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [KEY_IN_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Key drawn from the live table, the shared pool, or fresh random bits
    function automatic logic [KEY_IN_W-1:0] pick_key(int present_pct, int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < present_pct && dictionary.word_total > 0)
            return dictionary.stored_words[$urandom_range(0, dictionary.word_total - 1)];
        if (r < present_pct + pool_pct)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return rand_key();
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int insert_pct);
        int r;
        logic [CMD_W-1:0] odd_code;
        if ($urandom_range(0, 99) < insert_pct)
            return OP_INSERT;
        r = $urandom_range(0, 99);
        if (r < 3)
            return OP_CLEAR;
        if (r < 8) begin
            odd_code = CMD_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
            return odd_code;
        end
        if (r < 38)
            return OP_DELETE;
        if (r < 70)
            return OP_LOOKUP;
        return OP_UPDATE;
    endfunction

    // Present one transaction, hold it until accepted, then record it
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_IN_W-1:0] key,
                                input logic [KEY_IN_W-1:0] nkey);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_new_key <= nkey;
        do @(posedge aclk); while (!s_ready);
        dictionary.apply_command(cmd, key, nkey);
        items_sent++;
    endtask

    // Hold off new commands until every owed reply is back
    task automatic wait_for_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (dictionary.pending_replies.size() != 0);
    endtask

    // Random command mix with a per-segment insert bias
    task automatic run_mixed_segment(int len);
        int               insert_pct;
        logic [CMD_W-1:0] cmd;
        logic [KEY_IN_W-1:0] nkey;
        insert_pct = $urandom_range(20, 80);
        repeat (len) begin
            cmd  = pick_command(insert_pct);
            nkey = ($urandom_range(0, 99) < 60) ? pick_key(30, 50) : rand_key();
            send_command(cmd, pick_key(45, 35), nkey);
            if ($urandom_range(0, 49) == 0)
                wait_for_replies();
        end
    endtask

    // Clear, insert past capacity, then duplicate inserts and a lookup of stored words
    task automatic run_fill_segment();
        send_command(OP_CLEAR, rand_key(), rand_key());
        repeat (TABLE_DEPTH + 8) send_command(OP_INSERT, pick_key(10, 5), rand_key());
        repeat (2) send_command(OP_INSERT, pick_key(100, 0), rand_key());
        send_command(OP_LOOKUP, pick_key(100, 0), rand_key());
    endtask

    initial begin
        int len;
        int phase_start;
        logic [KEY_IN_W-1:0] word;

        dictionary = new();

        // Key pool: the extremes, packed lowercase words, raw random values
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            if (i % 2 == 0) begin
                key_pool[i] = rand_key();
            end else begin
                len = $urandom_range(1, 8);
                key_pool[i] = '0;
                for (int c = 0; c < len; c++)
                    key_pool[i][KEY_IN_W-1-8*c -: 8] = 8'h61 + 8'($urandom_range(0, 25));
            end
        end
        word = key_pool[3];

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extremes, duplicates, moves, odd codes
        send_command(OP_CLEAR, '0, '1);
        send_command(OP_LOOKUP, '0, '0);
        send_command(OP_DELETE, '0, '0);
        send_command(OP_UPDATE, '0, '1);
        send_command(OP_INSERT, '0, '1);
        send_command(OP_INSERT, '1, '0);
        send_command(OP_INSERT, '0, '0);
        send_command(OP_LOOKUP, '1, '0);
        send_command(OP_UPDATE, '0, '1);    // creates a second copy of all-ones
        send_command(OP_LOOKUP, '0, '0);
        send_command(OP_DELETE, '1, '0);    // lowest copy goes, last entry moves down
        send_command(OP_LOOKUP, '1, '0);
        send_command(OP_DELETE, '1, '0);
        send_command(OP_DELETE, '1, '0);    // table now empty
        send_command(OP_RSVD_A, '1, '1);
        send_command(OP_RSVD_B, word, '0);
        send_command(OP_RSVD_C, '0, word);
        send_command(OP_INSERT, word, ~word);
        send_command(OP_UPDATE, word, '0);
        send_command(OP_LOOKUP, '0, '1);
        send_command(OP_CLEAR, '1, '1);
        send_command(OP_LOOKUP, '0, '0);
        wait_for_replies();

        // Random phases: receiver-heavy idling, sender-heavy idling, none
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 24;
                    snk_idle_pct = 60;
                end
                1: begin
                    src_idle_pct = 60;
                    snk_idle_pct = 24;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) == 0)
                    run_fill_segment();
                else
                    run_mixed_segment(SEGMENT_LEN);
            end
            wait_for_replies();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (dictionary.errors == 0 && dictionary.pending_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
